// ----- hw/rtl/pic_pkg.sv -----
// pic_pkg: shared widths, latencies, status codes and bundle types for the
// polygon inset corner pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pic_pkg;

   localparam int LON_W    = 31;
   localparam int LAT_W    = 30;
   localparam int DIST_W   = 24;
   localparam int NRM_W    = 32;
   localparam int OUT_W    = 32;
   localparam int NUM_W    = 96;
   localparam int DET_W    = 64;
   localparam int REQ_W    = 184;
   localparam int RSP_W    = 64;
   localparam int STAT_W   = 2;

   localparam int SQRT_STEPS = 32;
   localparam int NDIV_STEPS = 31;
   localparam int QDIV_STEPS = 33;

   // register stages of each unit
   localparam int LAT_NRM   = 4 + SQRT_STEPS + 1 + NDIV_STEPS + 1;
   localparam int LAT_SLV   = 4;
   localparam int LAT_DIV   = 2 + QDIV_STEPS + 1;
   localparam int LAT_TOTAL = LAT_NRM + LAT_SLV + LAT_DIV;

   localparam logic signed [DIST_W-1:0] DIST_RESET = 24'sd104858;

   localparam logic [STAT_W-1:0] ST_NORMAL    = 2'd0;
   localparam logic [STAT_W-1:0] ST_PARALLEL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_ZERO_EDGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_SAT       = 2'd3;

   typedef struct packed {
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic signed [DET_W-1:0] det;
   } solve_type;

   typedef struct packed {
      logic                    zero;
      logic                    det_zero;
      logic signed [OUT_W-1:0] par_x;
      logic signed [OUT_W-1:0] par_y;
      logic signed [LON_W-1:0] cx;
      logic signed [LAT_W-1:0] cy;
   } side_type;

endpackage
`default_nettype wire

// ----- hw/rtl/pic_normal.sv -----
// pic_normal: pipelined unit left normal of one edge in Q1.30
// (normalize, sum of squares, digit-serial square root, restoring divide).
// Depends on pic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pic_normal
   import pic_pkg::*;
(
   input  wire                            clock,
   input  wire                            en,
   input  wire  logic signed [LON_W-1:0]  x0,
   input  wire  logic signed [LAT_W-1:0]  y0,
   input  wire  logic signed [LON_W-1:0]  x1,
   input  wire  logic signed [LAT_W-1:0]  y1,
   output logic signed [NRM_W-1:0]        nrm_x,
   output logic signed [NRM_W-1:0]        nrm_y,
   output logic                           zero
);

   logic signed [31:0] dx_ff, dy_ff;
   logic signed [31:0] sx_ff, sy_ff, sx_in, sy_in;
   logic               z2_ff, z2_in;
   logic [30:0]        ms_x, ms_y;
   logic [61:0]        qx_ff, qy_ff;
   logic signed [31:0] sx3_ff, sy3_ff;
   logic               z3_ff;
   logic [62:0]        sum_ff;
   logic signed [31:0] sx4_ff, sy4_ff;
   logic               z4_ff;

   // square root stages
   logic [33:0]        rt_rem_ff  [SQRT_STEPS];
   logic [33:0]        rt_rem_in  [SQRT_STEPS];
   logic [31:0]        rt_root_ff [SQRT_STEPS];
   logic [31:0]        rt_root_in [SQRT_STEPS];
   logic [63:0]        rt_x_ff    [SQRT_STEPS];
   logic [63:0]        rt_x_in    [SQRT_STEPS];
   logic signed [31:0] rt_sx_ff   [SQRT_STEPS];
   logic signed [31:0] rt_sy_ff   [SQRT_STEPS];
   logic               rt_z_ff    [SQRT_STEPS];

   // divide setup
   logic [31:0]        pr_rx_ff, pr_ry_ff, pr_rx_in, pr_ry_in;
   logic [30:0]        pr_bx_ff, pr_by_ff, pr_bx_in, pr_by_in;
   logic [31:0]        pr_len_ff;
   logic               pr_nx_ff, pr_ny_ff, pr_z_ff;

   // divide stages
   logic [31:0]        dv_rx_ff [NDIV_STEPS];
   logic [31:0]        dv_rx_in [NDIV_STEPS];
   logic [31:0]        dv_ry_ff [NDIV_STEPS];
   logic [31:0]        dv_ry_in [NDIV_STEPS];
   logic [30:0]        dv_bx_ff [NDIV_STEPS];
   logic [30:0]        dv_bx_in [NDIV_STEPS];
   logic [30:0]        dv_by_ff [NDIV_STEPS];
   logic [30:0]        dv_by_in [NDIV_STEPS];
   logic [30:0]        dv_qx_ff [NDIV_STEPS];
   logic [30:0]        dv_qx_in [NDIV_STEPS];
   logic [30:0]        dv_qy_ff [NDIV_STEPS];
   logic [30:0]        dv_qy_in [NDIV_STEPS];
   logic [31:0]        dv_len_ff [NDIV_STEPS];
   logic               dv_nx_ff [NDIV_STEPS];
   logic               dv_ny_ff [NDIV_STEPS];
   logic               dv_z_ff  [NDIV_STEPS];

   logic signed [NRM_W-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic                    out_z_ff;

   // normalize so the larger magnitude sits in [2^30, 2^31)
   always_comb begin
      logic [31:0] ax, ay, m;
      logic [4:0]  p;
      logic [4:0]  sh;
      ax = dx_ff[31] ? 32'(-dx_ff) : 32'(dx_ff);
      ay = dy_ff[31] ? 32'(-dy_ff) : 32'(dy_ff);
      m  = (ax > ay) ? ax : ay;
      p  = '0;
      for (int i = 0; i < 31; i++) begin
         if (m[i]) begin
            p = 5'(i);
         end
      end
      z2_in = (m == '0);
      sh    = z2_in ? 5'd0 : 5'(5'd30 - p);
      sx_in = dx_ff <<< sh;
      sy_in = dy_ff <<< sh;
   end

   // magnitudes of the scaled components
   assign ms_x = sx_ff[31] ? 31'(-sx_ff) : sx_ff[30:0];
   assign ms_y = sy_ff[31] ? 31'(-sy_ff) : sy_ff[30:0];

   // one result bit per square root stage
   always_comb begin
      logic [33:0] srem;
      logic [31:0] sroot;
      logic [63:0] sx;
      logic [35:0] r2, t;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (k == 0) begin
            srem  = '0;
            sroot = '0;
            sx    = {1'b0, sum_ff};
         end else begin
            srem  = rt_rem_ff[k-1];
            sroot = rt_root_ff[k-1];
            sx    = rt_x_ff[k-1];
         end
         r2 = {srem, sx[63:62]};
         t  = {2'b00, sroot, 2'b01};
         if (r2 >= t) begin
            rt_rem_in[k]  = 34'(r2 - t);
            rt_root_in[k] = {sroot[30:0], 1'b1};
         end else begin
            rt_rem_in[k]  = r2[33:0];
            rt_root_in[k] = {sroot[30:0], 1'b0};
         end
         rt_x_in[k] = {sx[61:0], 2'b00};
      end
   end

   // rounded numerators |s| * 2^30 + len / 2
   always_comb begin
      logic [31:0] len;
      logic signed [31:0] fsx, fsy;
      logic [31:0] mx, my;
      logic [61:0] nx, ny;
      len = rt_root_ff[SQRT_STEPS-1];
      fsx = rt_sx_ff[SQRT_STEPS-1];
      fsy = rt_sy_ff[SQRT_STEPS-1];
      mx  = fsx[31] ? 32'(-fsx) : 32'(fsx);
      my  = fsy[31] ? 32'(-fsy) : 32'(fsy);
      // normal x comes from -sy, normal y from sx
      nx  = {my[30:0], 30'b0} + 62'(len[31:1]);
      ny  = {mx[30:0], 30'b0} + 62'(len[31:1]);
      pr_rx_in = {1'b0, nx[61:31]};
      pr_bx_in = nx[30:0];
      pr_ry_in = {1'b0, ny[61:31]};
      pr_by_in = ny[30:0];
   end

   always_comb begin
      logic [31:0] rx, ry, len;
      logic [30:0] bx, by, qx, qy;
      logic [32:0] r2x, r2y, den;
      for (int k = 0; k < NDIV_STEPS; k++) begin
         if (k == 0) begin
            rx = pr_rx_ff; ry = pr_ry_ff; bx = pr_bx_ff; by = pr_by_ff;
            qx = '0; qy = '0; len = pr_len_ff;
         end else begin
            rx = dv_rx_ff[k-1]; ry = dv_ry_ff[k-1];
            bx = dv_bx_ff[k-1]; by = dv_by_ff[k-1];
            qx = dv_qx_ff[k-1]; qy = dv_qy_ff[k-1]; len = dv_len_ff[k-1];
         end
         den = {1'b0, len};
         r2x = {rx, bx[30]};
         r2y = {ry, by[30]};
         if (r2x >= den) begin
            dv_rx_in[k] = 32'(r2x - den);
            dv_qx_in[k] = {qx[29:0], 1'b1};
         end else begin
            dv_rx_in[k] = r2x[31:0];
            dv_qx_in[k] = {qx[29:0], 1'b0};
         end
         if (r2y >= den) begin
            dv_ry_in[k] = 32'(r2y - den);
            dv_qy_in[k] = {qy[29:0], 1'b1};
         end else begin
            dv_ry_in[k] = r2y[31:0];
            dv_qy_in[k] = {qy[29:0], 1'b0};
         end
         dv_bx_in[k] = {bx[29:0], 1'b0};
         dv_by_in[k] = {by[29:0], 1'b0};
      end
   end

   always_comb begin
      logic signed [NRM_W-1:0] qx, qy;
      qx = signed'(32'(dv_qx_ff[NDIV_STEPS-1]));
      qy = signed'(32'(dv_qy_ff[NDIV_STEPS-1]));
      out_x_in = dv_nx_ff[NDIV_STEPS-1] ? -qx : qx;
      out_y_in = dv_ny_ff[NDIV_STEPS-1] ? -qy : qy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= 32'(x1) - 32'(x0);
         dy_ff  <= 32'(y1) - 32'(y0);
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         z2_ff  <= z2_in;
         qx_ff  <= 62'(ms_x) * 62'(ms_x);
         qy_ff  <= 62'(ms_y) * 62'(ms_y);
         sx3_ff <= sx_ff;
         sy3_ff <= sy_ff;
         z3_ff  <= z2_ff;
         sum_ff <= 63'(qx_ff) + 63'(qy_ff);
         sx4_ff <= sx3_ff;
         sy4_ff <= sy3_ff;
         z4_ff  <= z3_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rt_rem_ff[k]  <= rt_rem_in[k];
            rt_root_ff[k] <= rt_root_in[k];
            rt_x_ff[k]    <= rt_x_in[k];
            rt_sx_ff[k]   <= (k == 0) ? sx4_ff : rt_sx_ff[k-1];
            rt_sy_ff[k]   <= (k == 0) ? sy4_ff : rt_sy_ff[k-1];
            rt_z_ff[k]    <= (k == 0) ? z4_ff  : rt_z_ff[k-1];
         end
         pr_rx_ff  <= pr_rx_in;
         pr_ry_ff  <= pr_ry_in;
         pr_bx_ff  <= pr_bx_in;
         pr_by_ff  <= pr_by_in;
         pr_len_ff <= rt_root_ff[SQRT_STEPS-1];
         pr_nx_ff  <= !rt_sy_ff[SQRT_STEPS-1][31] && (rt_sy_ff[SQRT_STEPS-1] != '0);
         pr_ny_ff  <= rt_sx_ff[SQRT_STEPS-1][31];
         pr_z_ff   <= rt_z_ff[SQRT_STEPS-1];
         for (int k = 0; k < NDIV_STEPS; k++) begin
            dv_rx_ff[k]  <= dv_rx_in[k];
            dv_ry_ff[k]  <= dv_ry_in[k];
            dv_bx_ff[k]  <= dv_bx_in[k];
            dv_by_ff[k]  <= dv_by_in[k];
            dv_qx_ff[k]  <= dv_qx_in[k];
            dv_qy_ff[k]  <= dv_qy_in[k];
            dv_len_ff[k] <= (k == 0) ? pr_len_ff : dv_len_ff[k-1];
            dv_nx_ff[k]  <= (k == 0) ? pr_nx_ff  : dv_nx_ff[k-1];
            dv_ny_ff[k]  <= (k == 0) ? pr_ny_ff  : dv_ny_ff[k-1];
            dv_z_ff[k]   <= (k == 0) ? pr_z_ff   : dv_z_ff[k-1];
         end
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= dv_z_ff[NDIV_STEPS-1];
      end
   end

   assign nrm_x = out_x_ff;
   assign nrm_y = out_y_ff;
   assign zero  = out_z_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/pic_solve.sv -----
// pic_solve: right-hand sides, determinant, wide numerators of the 2x2
// system and the parallel-edge fallback point. Depends on pic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pic_solve
   import pic_pkg::*;
(
   input  wire                             clock,
   input  wire                             en,
   input  wire  logic signed [NRM_W-1:0]   na,
   input  wire  logic signed [NRM_W-1:0]   nb,
   input  wire  logic signed [NRM_W-1:0]   nc,
   input  wire  logic signed [NRM_W-1:0]   nd,
   input  wire  logic signed [LON_W-1:0]   pxo,
   input  wire  logic signed [LAT_W-1:0]   pyo,
   input  wire  logic signed [LON_W-1:0]   cx,
   input  wire  logic signed [LAT_W-1:0]   cy,
   input  wire                             zero,
   input  wire  logic signed [DIST_W-1:0]  offset,
   output solve_type                       sol,
   output side_type                        side
);

   // t1: products
   logic signed [63:0] pa_ff, pb_ff, pc_ff, pd_ff, ad_ff, bc_ff, ax_ff, bx_ff;
   logic signed [NRM_W-1:0] a1_ff, b1_ff, c1_ff, d1_ff;
   logic signed [LON_W-1:0] cx1_ff;
   logic signed [LAT_W-1:0] cy1_ff;
   logic                    z1_ff;
   logic signed [63:0]      dsh_ff;

   // t2: sums
   logic signed [63:0] e_ff, f_ff, det2_ff, e_in, f_in;
   logic signed [OUT_W-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [NRM_W-1:0] a2_ff, b2_ff, c2_ff, d2_ff;
   logic signed [LON_W-1:0] cx2_ff;
   logic signed [LAT_W-1:0] cy2_ff;
   logic                    z2_ff;

   // t3: partial products of the wide numerators
   logic signed [64:0] del_ff, bfl_ff, afl_ff, cel_ff;
   logic signed [63:0] deh_ff, bfh_ff, afh_ff, ceh_ff;
   logic signed [63:0] det3_ff;
   side_type           side3_ff;

   solve_type sol_ff, sol_in;
   side_type  side_ff, side_in;

   function automatic logic signed [OUT_W-1:0] round_q30(
      input logic signed [63:0] p
   );
      logic [63:0] m;
      logic [63:0] q;
      begin
         m = p[63] ? 64'(-p) : 64'(p);
         q = (m + 64'd536870912) >> 30;
         round_q30 = p[63] ? -signed'(q[31:0]) : signed'(q[31:0]);
      end
   endfunction

   always_comb begin
      logic signed [OUT_W-1:0] cxe, cye;
      e_in  = dsh_ff + pa_ff + pb_ff;
      f_in  = dsh_ff + pc_ff + pd_ff;
      cxe   = OUT_W'(cx1_ff);
      cye   = OUT_W'(cy1_ff);
      px_in = cxe + round_q30(ax_ff);
      py_in = cye + round_q30(bx_ff);
   end

   always_comb begin
      logic signed [64:0] hx, hy;
      logic signed [65:0] lx, ly;
      logic signed [NUM_W-1:0] hx96, hy96, lx96, ly96;
      hx   = 65'(deh_ff) - 65'(bfh_ff);
      hy   = 65'(afh_ff) - 65'(ceh_ff);
      lx   = 66'(del_ff) - 66'(bfl_ff);
      ly   = 66'(afl_ff) - 66'(cel_ff);
      hx96 = NUM_W'(hx);
      hy96 = NUM_W'(hy);
      lx96 = NUM_W'(lx);
      ly96 = NUM_W'(ly);
      sol_in.num_x = (hx96 <<< 32) + lx96;
      sol_in.num_y = (hy96 <<< 32) + ly96;
      sol_in.det   = det3_ff;
      side_in          = side3_ff;
      side_in.det_zero = (det3_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= pxo * na;
         pb_ff  <= pyo * nb;
         pc_ff  <= cx * nc;
         pd_ff  <= cy * nd;
         ad_ff  <= na * nd;
         bc_ff  <= nb * nc;
         ax_ff  <= na * offset;
         bx_ff  <= nb * offset;
         dsh_ff <= 64'(offset) <<< 30;
         a1_ff  <= na;
         b1_ff  <= nb;
         c1_ff  <= nc;
         d1_ff  <= nd;
         cx1_ff <= cx;
         cy1_ff <= cy;
         z1_ff  <= zero;

         e_ff    <= e_in;
         f_ff    <= f_in;
         det2_ff <= ad_ff - bc_ff;
         px_ff   <= px_in;
         py_ff   <= py_in;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         c2_ff   <= c1_ff;
         d2_ff   <= d1_ff;
         cx2_ff  <= cx1_ff;
         cy2_ff  <= cy1_ff;
         z2_ff   <= z1_ff;

         del_ff  <= d2_ff * signed'({1'b0, e_ff[31:0]});
         bfl_ff  <= b2_ff * signed'({1'b0, f_ff[31:0]});
         afl_ff  <= a2_ff * signed'({1'b0, f_ff[31:0]});
         cel_ff  <= c2_ff * signed'({1'b0, e_ff[31:0]});
         deh_ff  <= d2_ff * signed'(e_ff[63:32]);
         bfh_ff  <= b2_ff * signed'(f_ff[63:32]);
         afh_ff  <= a2_ff * signed'(f_ff[63:32]);
         ceh_ff  <= c2_ff * signed'(e_ff[63:32]);
         det3_ff <= det2_ff;
         side3_ff.zero     <= z2_ff;
         side3_ff.det_zero <= 1'b0;
         side3_ff.par_x    <= px_ff;
         side3_ff.par_y    <= py_ff;
         side3_ff.cx       <= cx2_ff;
         side3_ff.cy       <= cy2_ff;

         sol_ff  <= sol_in;
         side_ff <= side_in;
      end
   end

   assign sol  = sol_ff;
   assign side = side_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/pic_qdiv.sv -----
// pic_qdiv: pipelined rounded signed divide of a 96-bit numerator by the
// determinant, one quotient bit per stage, with 32-bit saturation.
// Depends on pic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pic_qdiv
   import pic_pkg::*;
(
   input  wire                           clock,
   input  wire                           en,
   input  wire  logic signed [NUM_W-1:0] num,
   input  wire  logic signed [DET_W-1:0] det,
   output logic signed [OUT_W-1:0]       quo,
   output logic                          sat
);

   logic [NUM_W-1:0] m_ff;
   logic [DET_W-1:0] dm_ff;
   logic             neg_ff;

   logic [62:0]      ld_rem_ff;
   logic [32:0]      ld_bits_ff;
   logic [DET_W-1:0] ld_dm_ff;
   logic             ld_neg_ff, ld_big_ff;

   logic [62:0]      st_rem_ff  [QDIV_STEPS];
   logic [62:0]      st_rem_in  [QDIV_STEPS];
   logic [32:0]      st_bits_ff [QDIV_STEPS];
   logic [32:0]      st_bits_in [QDIV_STEPS];
   logic [32:0]      st_q_ff    [QDIV_STEPS];
   logic [32:0]      st_q_in    [QDIV_STEPS];
   logic [DET_W-1:0] st_dm_ff   [QDIV_STEPS];
   logic             st_neg_ff  [QDIV_STEPS];
   logic             st_big_ff  [QDIV_STEPS];

   logic signed [OUT_W-1:0] quo_ff, quo_in;
   logic                    sat_ff, sat_in;

   always_comb begin
      logic [62:0] rem;
      logic [32:0] bits, q;
      logic [DET_W-1:0] dm;
      logic [63:0] r2;
      for (int k = 0; k < QDIV_STEPS; k++) begin
         if (k == 0) begin
            rem = ld_rem_ff; bits = ld_bits_ff; q = '0; dm = ld_dm_ff;
         end else begin
            rem = st_rem_ff[k-1]; bits = st_bits_ff[k-1];
            q = st_q_ff[k-1]; dm = st_dm_ff[k-1];
         end
         r2 = {rem, bits[32]};
         if (r2 >= dm) begin
            st_rem_in[k] = 63'(r2 - dm);
            st_q_in[k]   = {q[31:0], 1'b1};
         end else begin
            st_rem_in[k] = r2[62:0];
            st_q_in[k]   = {q[31:0], 1'b0};
         end
         st_bits_in[k] = {bits[31:0], 1'b0};
      end
   end

   // round half away from zero, then clamp
   always_comb begin
      logic [33:0] qr;
      logic [33:0] limit;
      logic        ng;
      ng    = st_neg_ff[QDIV_STEPS-1];
      qr    = 34'(st_q_ff[QDIV_STEPS-1])
            + 34'({st_rem_ff[QDIV_STEPS-1], 1'b0} >= st_dm_ff[QDIV_STEPS-1]);
      limit = ng ? 34'h080000000 : 34'h07fffffff;
      sat_in = st_big_ff[QDIV_STEPS-1] || (qr > limit);
      if (sat_in) begin
         quo_in = ng ? signed'(32'h80000000) : signed'(32'h7fffffff);
      end else begin
         quo_in = ng ? -signed'(qr[31:0]) : signed'(qr[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         dm_ff  <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
         neg_ff <= num[NUM_W-1] != det[DET_W-1];

         // quotient of 2^33 or more always saturates
         ld_big_ff  <= 64'(m_ff[NUM_W-1:33]) >= dm_ff;
         ld_rem_ff  <= m_ff[NUM_W-2:33];
         ld_bits_ff <= m_ff[32:0];
         ld_dm_ff   <= dm_ff;
         ld_neg_ff  <= neg_ff;

         for (int k = 0; k < QDIV_STEPS; k++) begin
            st_rem_ff[k]  <= st_rem_in[k];
            st_bits_ff[k] <= st_bits_in[k];
            st_q_ff[k]    <= st_q_in[k];
            st_dm_ff[k]   <= (k == 0) ? ld_dm_ff  : st_dm_ff[k-1];
            st_neg_ff[k]  <= (k == 0) ? ld_neg_ff : st_neg_ff[k-1];
            st_big_ff[k]  <= (k == 0) ? ld_big_ff : st_big_ff[k-1];
         end

         quo_ff <= quo_in;
         sat_ff <= sat_in;
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/polygon_inset_corner.sv -----
// polygon_inset_corner: top level, stream ports, offset register, side-data
// delay lines and result select. Depends on pic_pkg, pic_normal, pic_solve,
// pic_qdiv.
`timescale 1ns / 1ps
`default_nettype none
// Takes one vertex triple (previous, corner, next) per cycle and returns the
// corner of the polygon inset by csr_wr_data's distance along both edge
// normals. Fully pipelined: a new triple is accepted every cycle while the
// output is not stalled; each result passes through the 32-step square root
// and 31-step normal divide per edge, then the 33-step quotient divide. A
// result that is not taken holds the whole pipeline, including req_tready.
// Status in rsp_tuser: normal, parallel-edge fallback, zero-length edge
// (corner returned unchanged), or saturated.
module polygon_inset_corner
   import pic_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   // prev_lon, prev_lat, corner_lon, corner_lat, next_lon, next_lat, 1 pad bit
   input  wire  [REQ_W-1:0]       req_tdata,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // inset_lon, inset_lat
   output logic [RSP_W-1:0]       rsp_tdata,
   // status
   output logic [STAT_W-1:0]      rsp_tuser,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire                    csr_wr_en,
   input  wire  [DIST_W-1:0]      csr_wr_data
);

   typedef struct packed {
      logic signed [LON_W-1:0] pxo;
      logic signed [LAT_W-1:0] pyo;
      logic signed [LON_W-1:0] cx;
      logic signed [LAT_W-1:0] cy;
   } crd_type;

   logic                     en;
   logic signed [DIST_W-1:0] dist_ff;
   logic [LAT_TOTAL-1:0]     vld_ff;
   crd_type                  crd_in;
   crd_type                  crd_ff  [LAT_NRM];
   side_type                 side_ff [LAT_DIV];

   logic signed [NRM_W-1:0]  na, nb, nc, nd;
   logic                     z1, z2;
   solve_type                sol;
   side_type                 side;
   logic signed [OUT_W-1:0]  qx, qy;
   logic                     sx, sy;

   logic [RSP_W-1:0]         out_data_ff, out_data_in;
   logic [STAT_W-1:0]        out_user_ff, out_user_in;
   logic                     out_vld_ff;

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   assign crd_in.pxo = signed'(req_tdata[30:0]);
   assign crd_in.pyo = signed'(req_tdata[60:31]);
   assign crd_in.cx  = signed'(req_tdata[91:61]);
   assign crd_in.cy  = signed'(req_tdata[121:92]);

   pic_normal u_nrm_in (
      .clock (clock),
      .en    (en),
      .x0    (crd_in.pxo),
      .y0    (crd_in.pyo),
      .x1    (crd_in.cx),
      .y1    (crd_in.cy),
      .nrm_x (na),
      .nrm_y (nb),
      .zero  (z1)
   );

   pic_normal u_nrm_out (
      .clock (clock),
      .en    (en),
      .x0    (crd_in.cx),
      .y0    (crd_in.cy),
      .x1    (signed'(req_tdata[152:122])),
      .y1    (signed'(req_tdata[182:153])),
      .nrm_x (nc),
      .nrm_y (nd),
      .zero  (z2)
   );

   pic_solve u_solve (
      .clock  (clock),
      .en     (en),
      .na     (na),
      .nb     (nb),
      .nc     (nc),
      .nd     (nd),
      .pxo    (crd_ff[LAT_NRM-1].pxo),
      .pyo    (crd_ff[LAT_NRM-1].pyo),
      .cx     (crd_ff[LAT_NRM-1].cx),
      .cy     (crd_ff[LAT_NRM-1].cy),
      .zero   (z1 || z2),
      .offset (dist_ff),
      .sol    (sol),
      .side   (side)
   );

   pic_qdiv u_div_x (
      .clock (clock),
      .en    (en),
      .num   (sol.num_x),
      .det   (sol.det),
      .quo   (qx),
      .sat   (sx)
   );

   pic_qdiv u_div_y (
      .clock (clock),
      .en    (en),
      .num   (sol.num_y),
      .det   (sol.det),
      .quo   (qy),
      .sat   (sy)
   );

   always_comb begin
      side_type                s;
      logic signed [OUT_W-1:0] rx, ry;
      s = side_ff[LAT_DIV-1];
      if (s.zero) begin
         rx          = OUT_W'(s.cx);
         ry          = OUT_W'(s.cy);
         out_user_in = ST_ZERO_EDGE;
      end else if (s.det_zero) begin
         rx          = s.par_x;
         ry          = s.par_y;
         out_user_in = ST_PARALLEL;
      end else begin
         rx          = qx;
         ry          = qy;
         out_user_in = (sx || sy) ? ST_SAT : ST_NORMAL;
      end
      out_data_in = {ry, rx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff    <= DIST_RESET;
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dist_ff <= signed'(csr_wr_data);
         end
         if (en) begin
            vld_ff     <= {vld_ff[LAT_TOTAL-2:0], req_tvalid};
            out_vld_ff <= vld_ff[LAT_TOTAL-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < LAT_NRM; k++) begin
            crd_ff[k] <= (k == 0) ? crd_in : crd_ff[k-1];
         end
         for (int k = 0; k < LAT_DIV; k++) begin
            side_ff[k] <= (k == 0) ? side : side_ff[k-1];
         end
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tvalid = out_vld_ff;

endmodule
`default_nettype wire
